>>> sv/asgr_pkg.sv
package asgr_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ESC  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    localparam logic [7:0] CH_BEL  = 8'h07;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_ESC  = 8'h1b;
    localparam logic [7:0] CH_LBRK = 8'h5b;
    localparam logic [7:0] CH_M    = 8'h6d;

    localparam logic [7:0] SGR_RESET      = 8'd0;
    localparam logic [7:0] SGR_BOLD       = 8'd1;
    localparam logic [7:0] SGR_FAINT      = 8'd2;
    localparam logic [7:0] SGR_INVERSE    = 8'd7;
    localparam logic [7:0] SGR_NORMAL     = 8'd22;
    localparam logic [7:0] SGR_NO_INVERSE = 8'd27;
    localparam logic [7:0] SGR_FG_BASE    = 8'd30;
    localparam logic [7:0] SGR_FG_LAST    = 8'd37;
    localparam logic [7:0] SGR_BG_BASE    = 8'd40;
    localparam logic [7:0] SGR_BG_LAST    = 8'd47;

    localparam logic [3:0] FORE_RESET = 4'd7;
    localparam logic [2:0] BACK_RESET = 3'd0;
    localparam logic [7:0] NUM_MAX    = 8'hff;

    localparam int DATA_IN_W  = 8;
    localparam int DATA_OUT_W = 64;

    function automatic logic [23:0] palette(input logic [3:0] idx);
        logic [23:0] rgb;
        case (idx)
            4'd0:    rgb = 24'h000000;
            4'd1:    rgb = 24'haa0000;
            4'd2:    rgb = 24'h00aa00;
            4'd3:    rgb = 24'haa5500;
            4'd4:    rgb = 24'h0000aa;
            4'd5:    rgb = 24'haa00aa;
            4'd6:    rgb = 24'h00aaaa;
            4'd7:    rgb = 24'haaaaaa;
            4'd8:    rgb = 24'h555555;
            4'd9:    rgb = 24'hff5555;
            4'd10:   rgb = 24'h55ff55;
            4'd11:   rgb = 24'hffff55;
            4'd12:   rgb = 24'h5555ff;
            4'd13:   rgb = 24'hff55ff;
            4'd14:   rgb = 24'h55ffff;
            default: rgb = 24'hffffff;
        endcase
        return rgb;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

>>> sv/ansi_sgr_color_parser_unit.sv
// A byte accepted into the input register is parsed there; its result goes to the output register.
// Throughput: one byte per cycle while the output is not stalled; the parse stage updates
// the sequence and color state from the input register.
// A stalled result holds the parse stage; one more byte fills the input register.
// Reset (rst_n, async, active low) clears the sequence state, sets
// foreground 7, background 0, inverse off, and empties both registers.
module ansi_sgr_color_parser_unit
    import asgr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DATA_IN_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tlast,   // end_of_chunk
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DATA_OUT_W-1:0] m_axis_tdata,   // char_code, fore_index, back_index,
                                                  // fore_rgb, back_rgb
    output logic                  m_axis_tuser    // is_backspace
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_eoc_reg;

    phase_t                phase_reg, phase_next;
    logic                  bracket_reg, bracket_next;
    logic [7:0]            num_reg, num_next;
    logic [1:0]            sep_reg, sep_next;
    logic [3:0]            fore_reg, fore_next;
    logic [2:0]            back_reg, back_next;
    logic                  inv_reg, inv_next;

    logic                  out_valid_reg;
    logic [DATA_OUT_W-1:0] out_data_reg;
    logic                  out_bs_reg;

    logic                  out_free;
    logic                  proc_fire;
    logic                  has_result;
    logic [11:0]           num_acc;
    logic [7:0]            fg_code;
    logic [7:0]            bg_code;
    logic [3:0]            f_idx;
    logic [3:0]            b_idx;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc_fire     = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    assign num_acc = {4'd0, num_reg} * 12'd10 + {4'd0, in_byte_reg - 8'h30};
    assign fg_code = num_reg - SGR_FG_BASE;
    assign bg_code = num_reg - SGR_BG_BASE;
    assign f_idx   = inv_reg ? {1'b0, back_reg} : fore_reg;
    assign b_idx   = inv_reg ? fore_reg : {1'b0, back_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        bracket_next = bracket_reg;
        num_next     = num_reg;
        sep_next     = sep_reg;
        fore_next    = fore_reg;
        back_next    = back_reg;
        inv_next     = inv_reg;
        has_result   = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (in_byte_reg == CH_ESC)
                begin
                    phase_next = PH_ESC;
                end
                else if (in_byte_reg != CH_BEL)
                begin
                    has_result = 1'b1;
                end
            end
            PH_ESC:
            begin
                bracket_next = (in_byte_reg == CH_LBRK);
                phase_next   = PH_BODY;
            end
            default:
            begin
                if (!bracket_reg)
                begin
                    phase_next   = PH_IDLE;
                    bracket_next = 1'b0;
                    num_next     = 8'd0;
                    sep_next     = 2'd0;
                end
                else if (is_letter(in_byte_reg))
                begin
                    if (in_byte_reg == CH_M && sep_reg == 2'd0)
                    begin
                        case (num_reg) inside
                            SGR_RESET:
                            begin
                                back_next = BACK_RESET;
                                fore_next = FORE_RESET;
                                inv_next  = 1'b0;
                            end
                            SGR_BOLD:                fore_next = {1'b1, fore_reg[2:0]};
                            SGR_FAINT, SGR_NORMAL:   fore_next = {1'b0, fore_reg[2:0]};
                            SGR_INVERSE:             inv_next  = 1'b1;
                            SGR_NO_INVERSE:          inv_next  = 1'b0;
                            [SGR_FG_BASE:SGR_FG_LAST]: fore_next = {fore_reg[3], fg_code[2:0]};
                            [SGR_BG_BASE:SGR_BG_LAST]: back_next = bg_code[2:0];
                            default:
                            begin
                            end
                        endcase
                    end
                    phase_next   = PH_IDLE;
                    bracket_next = 1'b0;
                    num_next     = 8'd0;
                    sep_next     = 2'd0;
                end
                else if (is_digit(in_byte_reg))
                begin
                    if (sep_reg == 2'd0)
                    begin
                        num_next = (num_acc > {4'd0, NUM_MAX}) ? NUM_MAX : num_acc[7:0];
                    end
                end
                else if (sep_reg != 2'd3)
                begin
                    sep_next = sep_reg + 2'd1;
                end
            end
        endcase
        if (in_eoc_reg)
        begin
            phase_next   = PH_IDLE;
            bracket_next = 1'b0;
            num_next     = 8'd0;
            sep_next     = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eoc_reg  <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            bracket_reg <= 1'b0;
            num_reg     <= 8'd0;
            sep_reg     <= 2'd0;
            fore_reg    <= FORE_RESET;
            back_reg    <= BACK_RESET;
            inv_reg     <= 1'b0;
        end
        else if (proc_fire)
        begin
            phase_reg   <= phase_next;
            bracket_reg <= bracket_next;
            num_reg     <= num_next;
            sep_reg     <= sep_next;
            fore_reg    <= fore_next;
            back_reg    <= back_next;
            inv_reg     <= inv_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire)
        begin
            out_valid_reg <= has_result;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && has_result)
        begin
            out_data_reg <= {palette(b_idx), palette(f_idx), b_idx, f_idx, in_byte_reg};
            out_bs_reg   <= (in_byte_reg == CH_BS);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_bs_reg;

    a_bs_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == CH_BS)
        else $error("backspace flag without backspace code");

    a_rgb_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:16] == palette(m_axis_tdata[11:8])
                       && m_axis_tdata[63:40] == palette(m_axis_tdata[15:12]))
        else $error("rgb does not match color index");

    a_eoc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && in_eoc_reg |=> phase_reg == PH_IDLE && num_reg == 8'd0
                                    && sep_reg == 2'd0 && !bracket_reg)
        else $error("end of chunk left sequence state");

    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_byte_reg)
                                      && $stable(in_eoc_reg))
        else $error("pending byte lost while output stalled");

endmodule
